// ===== src/sxd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sixel stream decoder package
// Shared constants, character codes, result kinds and the result record type.
// ----------------------------------------------------------------------------
package sxd_pkg;

    // Limits of the decoder.
    localparam int P_MAX_VAL   = 32767;
    localparam int P_MAX_CNT   = 32;
    localparam int P_PALETTE   = 256;
    localparam int P_MAX_COL   = 4096;
    localparam int P_MAX_ROW   = 1024;
    localparam int P_NSLOTS    = 5;

    // Result queue depth; it must hold two results beyond the one on the bus.
    localparam int Q_DEPTH     = 4;
    localparam int Q_PTR_W     = $clog2(Q_DEPTH);
    localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

    // Parser modes.
    localparam logic [2:0] MODE_UNINIT   = 3'd0;
    localparam logic [2:0] MODE_FINISHED = 3'd1;
    localparam logic [2:0] MODE_GROUND   = 3'd2;
    localparam logic [2:0] MODE_RASTER   = 3'd3;
    localparam logic [2:0] MODE_REPEAT   = 3'd4;
    localparam logic [2:0] MODE_COLOR    = 3'd5;

    // Result kinds.
    localparam logic [1:0] KIND_PAINT   = 2'd0;
    localparam logic [1:0] KIND_COLOR   = 2'd1;
    localparam logic [1:0] KIND_RASTER  = 2'd2;

    // Color models.
    localparam logic [14:0] MODEL_HLS = 15'd1;
    localparam logic [14:0] MODEL_RGB = 15'd2;

    // Input function codes.
    localparam logic FUNC_DATA   = 1'b0;
    localparam logic FUNC_FINISH = 1'b1;

    // Stream characters.
    localparam logic [7:0] CH_RASTER = 8'h22;  // '"'
    localparam logic [7:0] CH_REPEAT = 8'h21;  // '!'
    localparam logic [7:0] CH_COLOR  = 8'h23;  // '#'
    localparam logic [7:0] CH_NEWLN  = 8'h2D;  // '-'
    localparam logic [7:0] CH_CR     = 8'h24;  // '$'
    localparam logic [7:0] CH_SEMI   = 8'h3B;  // ';'
    localparam logic [7:0] CH_ZERO   = 8'h30;  // '0'
    localparam logic [7:0] CH_NINE   = 8'h39;  // '9'
    localparam logic [7:0] CH_SIX_LO = 8'h3F;  // '?'
    localparam logic [7:0] CH_SIX_HI = 8'h7E;  // '~'

    // Output tdata layout, lowest field first.
    localparam int TD_ROW_LSB   = 0;
    localparam int TD_COL_LSB   = 10;
    localparam int TD_RUN_LSB   = 22;
    localparam int TD_MASK_LSB  = 37;
    localparam int TD_CIDX_LSB  = 43;
    localparam int TD_A_LSB     = 52;
    localparam int TD_B_LSB     = 67;
    localparam int TD_C_LSB     = 82;
    localparam int TD_D_LSB     = 97;
    localparam int TD_PRES_LSB  = 112;
    localparam int TD_USED_W    = 116;
    localparam int TD_W         = 120;

    typedef struct packed {
        logic [1:0]  kind;
        logic [9:0]  row;
        logic [11:0] column;
        logic [14:0] run_length;
        logic [5:0]  mask;
        logic [8:0]  color_index;
        logic [14:0] arg_a;
        logic [14:0] arg_b;
        logic [14:0] arg_c;
        logic [14:0] arg_d;
        logic [3:0]  present;
        logic        last;
    } t_result;

    // Results of one transaction: an optional sequence report, then an
    // optional paint run.
    typedef struct packed {
        logic    valid_a;
        logic    valid_b;
        t_result res_a;
        t_result res_b;
    } t_step;

endpackage
`default_nettype wire

// ===== src/sxd_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sixel parser
// Holds the parser state and turns one character per cycle, while input is
// accepted, into up to two result records.
// ----------------------------------------------------------------------------
module sxd_parser
    import sxd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire logic       i_func,
    input  wire logic [7:0] i_ch,
    output t_step           o_step
);

    logic [2:0]  r_mode,  n_mode;
    logic [9:0]  r_row,   n_row;
    logic [11:0] r_col,   n_col;
    logic [14:0] r_rep,   n_rep;
    logic [8:0]  r_color, n_color;
    logic        r_seen,  n_seen;
    logic [14:0] r_pv [P_NSLOTS];
    logic [14:0] n_pv [P_NSLOTS];
    logic [5:0]  r_pcnt,  n_pcnt;
    logic [4:0]  r_given, n_given;
    logic        r_ovf,   n_ovf;

    // Parameter-character update, computed apart from the mode decode.
    logic        is_digit;
    logic        is_semi;
    logic [5:0]  cnt_eff;
    logic [5:0]  slot;
    logic [14:0] sel_val;
    logic [18:0] acc;
    logic [14:0] acc_sat;
    logic [14:0] pc_pv [P_NSLOTS];
    logic [5:0]  pc_cnt;
    logic [4:0]  pc_given;
    logic        pc_ovf;
    logic [14:0] pval [P_NSLOTS];

    always_comb begin
        is_digit = (i_ch >= CH_ZERO) && (i_ch <= CH_NINE);
        is_semi  = (i_ch == CH_SEMI);
        cnt_eff  = (r_pcnt == 6'd0) ? 6'd1 : r_pcnt;
        slot     = is_semi ? cnt_eff : cnt_eff - 6'd1;
        sel_val  = '0;
        for (int k = 0; k < P_NSLOTS; k++) begin
            pval[k] = r_given[k] ? r_pv[k] : 15'd0;
            if (slot == 6'(k)) begin
                sel_val = r_pv[k];
            end
        end
        acc     = ({4'd0, sel_val} << 3) + ({4'd0, sel_val} << 1) + {15'd0, i_ch[3:0]};
        acc_sat = (acc > 19'(P_MAX_VAL)) ? 15'(P_MAX_VAL) : acc[14:0];

        for (int k = 0; k < P_NSLOTS; k++) begin
            pc_pv[k] = r_pv[k];
        end
        pc_cnt   = r_pcnt;
        pc_given = r_given;
        pc_ovf   = r_ovf;
        if (!r_ovf) begin
            pc_cnt = cnt_eff;
            if (is_semi) begin
                if (cnt_eff >= 6'(P_MAX_CNT)) begin
                    pc_ovf = 1'b1;
                end else begin
                    pc_cnt = cnt_eff + 6'd1;
                end
            end
            for (int k = 0; k < P_NSLOTS; k++) begin
                if (slot == 6'(k) && !(is_semi && pc_ovf)) begin
                    pc_pv[k]    = is_semi ? 15'd0 : acc_sat;
                    pc_given[k] = !is_semi;
                end
            end
        end
    end

    // Main step.
    logic        take_param;
    logic        clear_p;
    logic [8:0]  idx;
    logic [15:0] col_sum;
    logic [5:0]  six;

    always_comb begin
        n_mode  = r_mode;
        n_row   = r_row;
        n_col   = r_col;
        n_rep   = r_rep;
        n_color = r_color;
        n_seen  = r_seen;
        n_pcnt  = r_pcnt;
        n_given = r_given;
        n_ovf   = r_ovf;
        for (int k = 0; k < P_NSLOTS; k++) begin
            n_pv[k] = r_pv[k];
        end
        o_step     = '0;
        take_param = 1'b0;
        clear_p    = 1'b0;
        idx        = (pval[0] > 15'(P_PALETTE)) ? 9'(P_PALETTE) : pval[0][8:0];
        col_sum    = '0;
        six        = i_ch[5:0] - CH_SIX_LO[5:0];

        if (i_func == FUNC_FINISH) begin
            if (r_mode != MODE_UNINIT) begin
                n_mode = MODE_FINISHED;
                n_row  = '0;
                n_col  = '0;
            end
        end else begin
            unique case (r_mode)
                MODE_RASTER: begin
                    if (is_digit || is_semi) begin
                        take_param = 1'b1;
                    end else if (!r_seen) begin
                        o_step.valid_a        = 1'b1;
                        o_step.res_a.kind     = KIND_RASTER;
                        o_step.res_a.arg_a    = pval[0];
                        o_step.res_a.arg_b    = pval[1];
                        o_step.res_a.arg_c    = pval[2];
                        o_step.res_a.arg_d    = pval[3];
                        o_step.res_a.present  = r_given[3:0];
                    end
                end
                MODE_REPEAT: begin
                    if (is_digit) begin
                        take_param = 1'b1;
                    end else begin
                        n_rep = (pval[0] != 15'd0) ? pval[0] : 15'd1;
                    end
                end
                MODE_COLOR: begin
                    if (is_digit || is_semi) begin
                        take_param = 1'b1;
                    end else begin
                        n_color = idx;
                        if (r_pcnt >= 6'(P_NSLOTS)
                                && (pval[1] == MODEL_HLS || pval[1] == MODEL_RGB)
                                && idx < 9'(P_PALETTE)) begin
                            o_step.valid_a           = 1'b1;
                            o_step.res_a.kind        = KIND_COLOR;
                            o_step.res_a.color_index = idx;
                            o_step.res_a.arg_a       = pval[1];
                            o_step.res_a.arg_b       = pval[2];
                            o_step.res_a.arg_c       = pval[3];
                            o_step.res_a.arg_d       = pval[4];
                        end
                    end
                end
                MODE_GROUND: begin
                end
                default: begin
                    // A new image starts from a clean state.
                    n_row   = '0;
                    n_col   = '0;
                    n_rep   = 15'd1;
                    n_color = 9'd15;
                    n_seen  = 1'b0;
                    clear_p = 1'b1;
                end
            endcase

            if (take_param) begin
                n_pcnt  = pc_cnt;
                n_given = pc_given;
                n_ovf   = pc_ovf;
                for (int k = 0; k < P_NSLOTS; k++) begin
                    n_pv[k] = pc_pv[k];
                end
            end else begin
                n_mode = MODE_GROUND;
                unique case (i_ch)
                    CH_RASTER: begin
                        n_mode  = MODE_RASTER;
                        clear_p = 1'b1;
                    end
                    CH_REPEAT: begin
                        n_mode  = MODE_REPEAT;
                        clear_p = 1'b1;
                    end
                    CH_COLOR: begin
                        n_mode  = MODE_COLOR;
                        clear_p = 1'b1;
                    end
                    CH_NEWLN: begin
                        if (n_row < 10'(P_MAX_ROW - 1)) begin
                            n_row = n_row + 10'd1;
                        end
                        n_col = '0;
                    end
                    CH_CR: begin
                        n_col = '0;
                    end
                    default: begin
                        if (i_ch >= CH_SIX_LO && i_ch <= CH_SIX_HI) begin
                            if (six != 6'd0) begin
                                o_step.valid_b           = 1'b1;
                                o_step.res_b.kind        = KIND_PAINT;
                                o_step.res_b.row         = n_row;
                                o_step.res_b.column      = n_col;
                                o_step.res_b.run_length  = n_rep;
                                o_step.res_b.mask        = six;
                                o_step.res_b.color_index = n_color;
                            end
                            col_sum = {4'd0, n_col} + {1'b0, n_rep};
                            n_col   = (col_sum > 16'(P_MAX_COL - 1))
                                    ? 12'(P_MAX_COL - 1) : col_sum[11:0];
                            n_rep   = 15'd1;
                        end
                    end
                endcase
                if (n_mode != MODE_RASTER) begin
                    n_seen = 1'b1;
                end
                if (clear_p) begin
                    n_pcnt  = 6'd1;
                    n_given = '0;
                    n_ovf   = 1'b0;
                    for (int k = 0; k < P_NSLOTS; k++) begin
                        n_pv[k] = '0;
                    end
                end
                if (o_step.valid_b) begin
                    o_step.res_b.last = 1'b1;
                end else begin
                    o_step.res_a.last = o_step.valid_a;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_UNINIT;
            r_row   <= '0;
            r_col   <= '0;
            r_rep   <= 15'd1;
            r_color <= 9'd15;
            r_seen  <= 1'b0;
            r_pcnt  <= '0;
            r_given <= '0;
            r_ovf   <= 1'b0;
            for (int k = 0; k < P_NSLOTS; k++) begin
                r_pv[k] <= '0;
            end
        end else if (i_accept) begin
            r_mode  <= n_mode;
            r_row   <= n_row;
            r_col   <= n_col;
            r_rep   <= n_rep;
            r_color <= n_color;
            r_seen  <= n_seen;
            r_pcnt  <= n_pcnt;
            r_given <= n_given;
            r_ovf   <= n_ovf;
            for (int k = 0; k < P_NSLOTS; k++) begin
                r_pv[k] <= n_pv[k];
            end
        end
    end

endmodule
`default_nettype wire

// ===== src/sxd_result_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sixel result queue
// Small register queue that takes up to two results per cycle and hands one
// per cycle to the output bus while the receiver is ready.
// ----------------------------------------------------------------------------
module sxd_result_queue
    import sxd_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_step i_step,
    output logic       o_space,
    output logic       o_valid,
    input  wire logic  i_ready,
    output t_result    o_res
);

    t_result              r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wptr, n_wptr;
    logic [Q_PTR_W-1:0]   r_rptr, n_rptr;
    logic [Q_CNT_W-1:0]   r_cnt,  n_cnt;
    logic                 push_a;
    logic                 push_b;
    logic                 pop;
    logic [1:0]           n_push;
    t_result              first;

    always_comb begin
        push_a  = i_push && i_step.valid_a;
        push_b  = i_push && i_step.valid_b;
        n_push  = {1'b0, push_a} + {1'b0, push_b};
        first   = push_a ? i_step.res_a : i_step.res_b;
        pop     = o_valid && i_ready;
        n_wptr  = r_wptr + Q_PTR_W'(n_push);
        n_rptr  = r_rptr + Q_PTR_W'(pop);
        n_cnt   = r_cnt + Q_CNT_W'(n_push) - Q_CNT_W'(pop);
        o_valid = (r_cnt != '0);
        o_space = (r_cnt <= Q_CNT_W'(Q_DEPTH - 2));
        o_res   = r_mem[r_rptr];
    end

    always_ff @(posedge i_clk) begin
        if (push_a || push_b) begin
            r_mem[r_wptr] <= first;
        end
        if (push_a && push_b) begin
            r_mem[r_wptr + Q_PTR_W'(1)] <= i_step.res_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

endmodule
`default_nettype wire

// ===== src/sixel_stream_decoder.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sixel stream decoder
// Parses a sixel character stream into paint runs, palette definitions and
// raster attributes.
// ----------------------------------------------------------------------------
// The input channel carries one character per transaction in tdata, with the
// function flag in tuser (0 data character, 1 finish image). The output
// channel carries one result per transaction: the kind in tuser, tlast on the
// final result caused by an input character, the other fields in tdata.
// The parser updates its state in the cycle a character is taken and writes
// its results into a four-entry result queue, so each result is registered
// in the queue and appears on the output only after the input transaction.
// A character gives at most two results: a palette or raster report that the
// character closes, then its paint run. The input is taken every cycle while
// the queue has room for two results, so one character per cycle is sustained
// when each gives at most one result and the receiver is ready; a character
// with two results takes two output transactions. When the receiver stalls,
// the queue fills and input ready drops once fewer than two entries are free;
// the head result stays on the bus unchanged. Reset empties the queue and puts
// the parser in its uninitialized mode, in which a finish does nothing and the
// first data character starts a new image.
// ----------------------------------------------------------------------------
module sixel_stream_decoder
    import sxd_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  wire logic [7:0]        i_s_axis_tdata,   // [7:0] ch
    input  wire logic [0:0]        i_s_axis_tuser,   // [0] func
    output logic                   o_m_axis_tvalid,
    input  wire logic              i_m_axis_tready,
    // [9:0] row, [21:10] column, [36:22] run_length, [42:37] mask,
    // [51:43] color_index, [66:52] arg_a, [81:67] arg_b, [96:82] arg_c,
    // [111:97] arg_d, [115:112] present, [119:116] zero
    output logic [TD_W-1:0]        o_m_axis_tdata,
    output logic [1:0]             o_m_axis_tuser,   // [1:0] kind
    output logic                   o_m_axis_tlast
);

    logic    accept;
    logic    space;
    t_step   step;
    t_result head;

    assign o_s_axis_tready = space;
    assign accept          = i_s_axis_tvalid && space;

    sxd_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_func   (i_s_axis_tuser[0]),
        .i_ch     (i_s_axis_tdata),
        .o_step   (step)
    );

    sxd_result_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (accept),
        .i_step   (step),
        .o_space  (space),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_res    (head)
    );

    assign o_m_axis_tdata = {(TD_W - TD_USED_W)'(0), head.present, head.arg_d, head.arg_c,
                             head.arg_b, head.arg_a, head.color_index, head.mask,
                             head.run_length, head.column, head.row};
    assign o_m_axis_tuser = head.kind;
    assign o_m_axis_tlast = head.last;

endmodule
`default_nettype wire

// ===== src/sxd_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sixel decoder checker
// Port-level assertions on the output channel of the decoder.
// ----------------------------------------------------------------------------
module sxd_checker
    import sxd_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_m_axis_tready,
    input  wire logic            o_m_axis_tvalid,
    input  wire logic [TD_W-1:0] o_m_axis_tdata,
    input  wire logic [1:0]      o_m_axis_tuser,
    input  wire logic            o_m_axis_tlast
);

    logic [9:0]  row;
    logic [11:0] column;
    logic [14:0] run_length;
    logic [5:0]  mask;

    assign row        = o_m_axis_tdata[TD_ROW_LSB +: 10];
    assign column     = o_m_axis_tdata[TD_COL_LSB +: 12];
    assign run_length = o_m_axis_tdata[TD_RUN_LSB +: 15];
    assign mask       = o_m_axis_tdata[TD_MASK_LSB +: 6];

    // The result queue is empty right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

    // Paint runs always paint something over at least one column; reports
    // carry no mask and no position.
    a_paint_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            (o_m_axis_tuser == KIND_PAINT) ? (mask != 6'd0 && run_length != 15'd0)
                                           : (mask == 6'd0 && row == 10'd0 && column == 12'd0))
        else $error("result fields do not match kind");

    // Only a report can be followed by another result of the same character,
    // and that result is already queued.
    a_nonlast_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tlast |-> o_m_axis_tuser != KIND_PAINT)
        else $error("paint run without tlast");

    a_nonlast_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && i_m_axis_tready && !o_m_axis_tlast |=> o_m_axis_tvalid)
        else $error("second result of a character missing");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)
            && $stable(o_m_axis_tlast))
        else $error("output changed while stalled");

endmodule

bind sixel_stream_decoder sxd_checker u_sxd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tlast  (o_m_axis_tlast)
);
`default_nettype wire

// ===== bench/sixel_result_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sixel decoder result checker
// Watches both stream channels of the decoder and keeps its own copy of the
// parser state. It predicts the results of every input transaction and
// compares each output transaction, field by field, with the oldest
// prediction.
// ----------------------------------------------------------------------------
module sixel_result_checker
    import sxd_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_s_axis_tvalid,
    input  wire logic            i_s_axis_tready,
    input  wire logic [7:0]      i_s_axis_tdata,   // [7:0] ch
    input  wire logic [0:0]      i_s_axis_tuser,   // [0] func
    input  wire logic            i_m_axis_tvalid,
    input  wire logic            i_m_axis_tready,
    // [9:0] row, [21:10] column, [36:22] run_length, [42:37] mask,
    // [51:43] color_index, [66:52] arg_a, [81:67] arg_b, [96:82] arg_c,
    // [111:97] arg_d, [115:112] present, [119:116] zero
    input  wire logic [TD_W-1:0] i_m_axis_tdata,
    input  wire logic [1:0]      i_m_axis_tuser,   // [1:0] kind
    input  wire logic            i_m_axis_tlast,
    output int                   o_fail_count,
    output int                   o_pending
);

    // Parser state as the decoder should hold it.
    logic [2:0]  mode;
    logic [9:0]  cur_row;
    logic [11:0] cur_col;
    logic [14:0] rep_count;
    logic [8:0]  cur_color;
    logic        seen_data;
    int unsigned param_vals [P_NSLOTS];
    int unsigned param_cnt;
    logic [4:0]  param_given;
    logic        param_ovf;

    t_result     pending_results [$];
    int          fail_count = 0;
    int          pending_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_count;

    function automatic int unsigned param_value(input int k);
        return param_given[k] ? param_vals[k] : 0;
    endfunction

    task automatic clear_params();
        foreach (param_vals[k]) param_vals[k] = 0;
        param_cnt   = 1;
        param_given = '0;
        param_ovf   = 1'b0;
    endtask

    task automatic take_param_char(input logic [7:0] ch);
        int unsigned slot;
        int unsigned v;
        if (param_ovf) return;
        if (param_cnt == 0) param_cnt = 1;
        if (ch == CH_SEMI) begin
            // Past the count limit the rest of the sequence is dropped.
            if (param_cnt >= P_MAX_CNT) begin
                param_ovf = 1'b1;
            end else begin
                param_cnt++;
                slot = param_cnt - 1;
                if (slot < P_NSLOTS) begin
                    param_vals[slot]  = 0;
                    param_given[slot] = 1'b0;
                end
            end
        end else begin
            slot = param_cnt - 1;
            if (slot < P_NSLOTS) begin
                v = param_vals[slot] * 10 + (ch - CH_ZERO);
                if (v > P_MAX_VAL) v = P_MAX_VAL;
                param_vals[slot]  = v;
                param_given[slot] = 1'b1;
            end
        end
    endtask

    // Works out the results of one input transaction and queues them.
    task automatic decode_char(input logic func, input logic [7:0] ch);
        t_result     step_out [$];
        t_result     r;
        logic        digit;
        int unsigned idx;
        int unsigned model;
        int unsigned nc;
        logic [5:0]  bits;
        digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
        if (func == FUNC_FINISH) begin
            if (mode != MODE_UNINIT) begin
                mode    = MODE_FINISHED;
                cur_row = '0;
                cur_col = '0;
            end
            return;
        end
        case (mode)
            MODE_RASTER: begin
                if (digit || ch == CH_SEMI) begin
                    take_param_char(ch);
                    return;
                end
                if (!seen_data) begin
                    r = '0;
                    r.kind    = KIND_RASTER;
                    r.arg_a   = 15'(param_value(0));
                    r.arg_b   = 15'(param_value(1));
                    r.arg_c   = 15'(param_value(2));
                    r.arg_d   = 15'(param_value(3));
                    r.present = param_given[3:0];
                    step_out.insert(step_out.size(), r);
                end
            end
            MODE_REPEAT: begin
                if (digit) begin
                    take_param_char(ch);
                    return;
                end
                rep_count = (param_value(0) != 0) ? 15'(param_value(0)) : 15'd1;
            end
            MODE_COLOR: begin
                if (digit || ch == CH_SEMI) begin
                    take_param_char(ch);
                    return;
                end
                idx = param_value(0);
                if (idx > P_PALETTE) idx = P_PALETTE;
                cur_color = 9'(idx);
                if (param_cnt >= 5) begin
                    model = param_value(1);
                    if ((model == MODEL_HLS || model == MODEL_RGB) && idx < P_PALETTE) begin
                        r = '0;
                        r.kind        = KIND_COLOR;
                        r.color_index = 9'(idx);
                        r.arg_a       = 15'(model);
                        r.arg_b       = 15'(param_value(2));
                        r.arg_c       = 15'(param_value(3));
                        r.arg_d       = 15'(param_value(4));
                        step_out.insert(step_out.size(), r);
                    end
                end
            end
            MODE_GROUND: ;
            default: begin
                // First data character of a new image.
                cur_row   = '0;
                cur_col   = '0;
                rep_count = 15'd1;
                cur_color = 9'd15;
                seen_data = 1'b0;
                clear_params();
            end
        endcase
        mode = MODE_GROUND;
        case (ch)
            CH_RASTER: begin
                mode = MODE_RASTER;
                clear_params();
            end
            CH_REPEAT: begin
                mode = MODE_REPEAT;
                clear_params();
            end
            CH_COLOR: begin
                mode = MODE_COLOR;
                clear_params();
            end
            CH_NEWLN: begin
                if (cur_row < P_MAX_ROW - 1) cur_row++;
                cur_col = '0;
            end
            CH_CR: cur_col = '0;
            default: begin
                if (ch >= CH_SIX_LO && ch <= CH_SIX_HI) begin
                    bits = 6'(ch - CH_SIX_LO);
                    if (bits != 0) begin
                        r = '0;
                        r.kind        = KIND_PAINT;
                        r.row         = cur_row;
                        r.column      = cur_col;
                        r.run_length  = rep_count;
                        r.mask        = bits;
                        r.color_index = cur_color;
                        step_out.insert(step_out.size(), r);
                    end
                    nc        = cur_col + rep_count;
                    cur_col   = (nc > P_MAX_COL - 1) ? 12'(P_MAX_COL - 1) : 12'(nc);
                    rep_count = 15'd1;
                end
            end
        endcase
        // Any character handled in ground, except a raster start, counts as data.
        if (mode != MODE_RASTER) seen_data = 1'b1;
        if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
        foreach (step_out[k]) pending_results.insert(pending_results.size(), step_out[k]);
    endtask

    function automatic void compare_field(input string name, input int unsigned want,
                                          input int unsigned got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            fail_count++;
        end
    endfunction

    task automatic check_result();
        t_result want;
        t_result got;
        got.kind        = i_m_axis_tuser;
        got.row         = i_m_axis_tdata[TD_ROW_LSB  +: 10];
        got.column      = i_m_axis_tdata[TD_COL_LSB  +: 12];
        got.run_length  = i_m_axis_tdata[TD_RUN_LSB  +: 15];
        got.mask        = i_m_axis_tdata[TD_MASK_LSB +: 6];
        got.color_index = i_m_axis_tdata[TD_CIDX_LSB +: 9];
        got.arg_a       = i_m_axis_tdata[TD_A_LSB    +: 15];
        got.arg_b       = i_m_axis_tdata[TD_B_LSB    +: 15];
        got.arg_c       = i_m_axis_tdata[TD_C_LSB    +: 15];
        got.arg_d       = i_m_axis_tdata[TD_D_LSB    +: 15];
        got.present     = i_m_axis_tdata[TD_PRES_LSB +: 4];
        got.last        = i_m_axis_tlast;
        if (pending_results.size() == 0) begin
            $display("%0t ns: unexpected result, expected nothing, got kind %0d tdata %h",
                     $time, got.kind, i_m_axis_tdata);
            fail_count++;
            return;
        end
        want = pending_results[0];
        pending_results.delete(0);
        compare_field("kind",        want.kind,        got.kind);
        compare_field("row",         want.row,         got.row);
        compare_field("column",      want.column,      got.column);
        compare_field("run_length",  want.run_length,  got.run_length);
        compare_field("mask",        want.mask,        got.mask);
        compare_field("color_index", want.color_index, got.color_index);
        compare_field("arg_a",       want.arg_a,       got.arg_a);
        compare_field("arg_b",       want.arg_b,       got.arg_b);
        compare_field("arg_c",       want.arg_c,       got.arg_c);
        compare_field("arg_d",       want.arg_d,       got.arg_d);
        compare_field("present",     want.present,     got.present);
        compare_field("last",        want.last,        got.last);
        compare_field("tdata padding", 0, i_m_axis_tdata[TD_W-1:TD_USED_W]);
    endtask

    // Output transactions are checked before the input of the same edge is
    // decoded, since a result never leaves in the cycle its character enters.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            mode      = MODE_UNINIT;
            cur_row   = '0;
            cur_col   = '0;
            rep_count = 15'd1;
            cur_color = 9'd15;
            seen_data = 1'b0;
            foreach (param_vals[k]) param_vals[k] = 0;
            param_cnt   = 0;
            param_given = '0;
            param_ovf   = 1'b0;
            pending_results.delete();
        end else begin
            if (i_m_axis_tvalid && i_m_axis_tready) check_result();
            if (i_s_axis_tvalid && i_s_axis_tready) decode_char(i_s_axis_tuser[0], i_s_axis_tdata);
        end
        pending_count = pending_results.size();
    end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sixel stream decoder testbench
// Feeds the decoder a directed character stream, a short run of band breaks
// between paint runs, and random well-formed and broken sequences, with
// random idling on both channels. A checker beside the decoder predicts and
// compares every result.
// ----------------------------------------------------------------------------
module testbench;
    import sxd_pkg::*;

    typedef struct packed {
        logic       func;
        logic [7:0] ch;
    } t_stream_char;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic [7:0]       s_axis_tdata = '0;
    logic [0:0]       s_axis_tuser = '0;
    logic             m_axis_tready = 1'b0;
    wire logic        s_axis_tready;
    wire logic        m_axis_tvalid;
    wire logic [TD_W-1:0] m_axis_tdata;
    wire logic [1:0]  m_axis_tuser;
    wire logic        m_axis_tlast;
    int               fail_count;
    int               pending_count;

    t_stream_char     char_list [$];
    int               random_start = 0;
    int               sent_count = 0;
    logic             quiet = 1'b0;
    logic             held = 1'b0;

    always #10 clk = ~clk;

    sixel_stream_decoder dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_axis_tvalid),
        .o_s_axis_tready (s_axis_tready),
        .i_s_axis_tdata  (s_axis_tdata),
        .i_s_axis_tuser  (s_axis_tuser),
        .o_m_axis_tvalid (m_axis_tvalid),
        .i_m_axis_tready (m_axis_tready),
        .o_m_axis_tdata  (m_axis_tdata),
        .o_m_axis_tuser  (m_axis_tuser),
        .o_m_axis_tlast  (m_axis_tlast)
    );

    sixel_result_checker result_check (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_axis_tvalid),
        .i_s_axis_tready (s_axis_tready),
        .i_s_axis_tdata  (s_axis_tdata),
        .i_s_axis_tuser  (s_axis_tuser),
        .i_m_axis_tvalid (m_axis_tvalid),
        .i_m_axis_tready (m_axis_tready),
        .i_m_axis_tdata  (m_axis_tdata),
        .i_m_axis_tuser  (m_axis_tuser),
        .i_m_axis_tlast  (m_axis_tlast),
        .o_fail_count    (fail_count),
        .o_pending       (pending_count)
    );

    task automatic push_char(input logic func, input logic [7:0] ch);
        t_stream_char c;
        c.func = func;
        c.ch   = ch;
        char_list.insert(char_list.size(), c);
    endtask

    task automatic push_data(input logic [7:0] ch);
        push_char(FUNC_DATA, ch);
    endtask

    task automatic push_finish();
        push_char(FUNC_FINISH, 8'($urandom));
    endtask

    task automatic push_decimal(input int unsigned v);
        string s;
        s = $sformatf("%0d", v);
        if ($urandom_range(0, 9) == 0) push_data(CH_ZERO);
        foreach (s[k]) push_data(s[k]);
    endtask

    // A parameter that may be absent, small, or large enough to saturate.
    task automatic push_param();
        int pick;
        pick = $urandom_range(0, 7);
        if (pick == 0) return;
        if (pick <= 4) push_decimal($urandom_range(0, 9));
        else if (pick <= 6) push_decimal($urandom_range(0, 999));
        else push_decimal($urandom_range(30000, 99999));
    endtask

    task automatic push_sixel();
        push_data(CH_SIX_LO + 8'($urandom_range(0, 63)));
    endtask

    // Ends a sequence mostly with a sixel character, sometimes with anything.
    task automatic push_terminator();
        if ($urandom_range(0, 3) != 0) push_sixel();
        else push_data(8'($urandom));
    endtask

    task automatic add_random_segment();
        int pick;
        int n;
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            repeat ($urandom_range(1, 6)) push_sixel();
        end else if (pick < 45) begin
            push_data(CH_REPEAT);
            if ($urandom_range(0, 9) == 0) begin
                push_data(8'($urandom));
            end else begin
                push_param();
                push_sixel();
            end
        end else if (pick < 60) begin
            push_data(CH_COLOR);
            if ($urandom_range(0, 7) == 0) push_decimal($urandom_range(250, 400));
            else push_decimal($urandom_range(0, 255));
            if ($urandom_range(0, 14) == 0) begin
                // Enough separators to run past the parameter count limit.
                repeat ($urandom_range(P_MAX_CNT, P_MAX_CNT + 8)) begin
                    push_data(CH_SEMI);
                    if ($urandom_range(0, 3) == 0) push_param();
                end
            end else begin
                n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 6) : 4;
                for (int k = 1; k <= n; k++) begin
                    push_data(CH_SEMI);
                    if (k == 1) begin
                        if ($urandom_range(0, 5) == 0) push_param();
                        else push_decimal($urandom_range(MODEL_HLS, MODEL_RGB));
                    end else begin
                        push_param();
                    end
                end
            end
            push_terminator();
        end else if (pick < 68) begin
            // Mostly at the start of a fresh image, where raster attributes count.
            if ($urandom_range(0, 9) < 7) push_finish();
            push_data(CH_RASTER);
            n = $urandom_range(0, 5);
            for (int k = 0; k < n; k++) begin
                if (k > 0) push_data(CH_SEMI);
                push_param();
            end
            push_terminator();
        end else if (pick < 76) begin
            push_data($urandom_range(0, 1) ? CH_NEWLN : CH_CR);
        end else if (pick < 90) begin
            push_data(8'($urandom));
        end else if (pick < 95) begin
            push_finish();
        end else begin
            repeat ($urandom_range(1, 4)) begin
                if ($urandom_range(0, 3) == 0) push_data(CH_SEMI);
                else push_data(CH_ZERO + 8'($urandom_range(0, 9)));
            end
        end
    endtask

    task automatic build_stimulus();
        // A finish before any image does nothing.
        push_finish();
        // Raster attributes with an absent middle parameter, closed by a color.
        push_data(CH_RASTER);
        push_data(CH_ZERO + 8'd1);
        push_data(CH_SEMI);
        push_data(CH_SEMI);
        push_data(CH_ZERO + 8'd7);
        push_data(CH_COLOR);
        // Full RGB definition with one empty component, closed by a full mask:
        // this character gives both a palette report and a paint run.
        push_data(CH_ZERO + 8'd3);
        push_data(CH_SEMI);
        push_data(CH_ZERO + 8'd2);
        push_data(CH_SEMI);
        push_data(CH_ZERO + 8'd9);
        push_data(CH_SEMI);
        push_data(CH_SEMI);
        push_data(CH_ZERO + 8'd5);
        push_data(CH_SIX_HI);
        // A zero repeat counts as one; an empty mask only moves the cursor.
        push_data(CH_REPEAT);
        push_data(CH_ZERO);
        push_data(CH_SIX_LO);
        // Saturating repeat count, then the column saturates.
        push_data(CH_REPEAT);
        push_decimal(99999);
        push_data(CH_SIX_LO + 8'd1);
        push_data(CH_SIX_LO + 8'd2);
        push_data(CH_CR);
        push_data(CH_NEWLN);
        push_data(8'h00);
        push_data(8'hFF);
        push_finish();
        // A short run of band breaks between paint runs.
        for (int k = 0; k < 20; k++) begin
            push_data(CH_NEWLN);
            if (k % 4 == 0) push_sixel();
        end
        push_data(CH_SIX_HI);
        push_data(CH_SIX_LO + 8'd1);
        push_finish();
        random_start = char_list.size();
        while (char_list.size() < 650) add_random_segment();
    endtask

    initial begin
        build_stimulus();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (char_list[i]) begin
            if (i >= char_list.size() - 60) quiet = 1'b1;
            if (!quiet && $urandom_range(0, 7) == 0) begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tuser  <= char_list[i].func;
            s_axis_tdata  <= char_list[i].ch;
            @(posedge clk);
            while (!s_axis_tready) @(posedge clk);
            sent_count++;
        end
        s_axis_tvalid <= 1'b0;
        @(negedge clk);
        while (pending_count != 0) @(negedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Receiver side: random stalls, one long hold-off so the result queue
    // fills and the decoder stops taking characters.
    initial begin
        @(posedge clk);
        forever begin
            if (!held && sent_count > random_start + 100) begin
                held = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (80) @(posedge clk);
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end else begin
                m_axis_tready <= 1'b1;
                repeat (quiet ? 1 : $urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    initial begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
